// ----- design/index_free_list_allocator_core_assert.svh -----
// assertion macros for the index free list allocator
`ifndef INDEX_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define INDEX_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define IFLA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ifla check failed");
`define IFLA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ifla check failed");
`else
`define IFLA_ASSERT(label, clk, rst_n, prop)
`define IFLA_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- design/ifla_pkg.sv -----
// shared types and constants for the index free list allocator
`default_nettype none

package ifla_pkg;

  localparam int NUM_SLOTS = 1024;
  localparam int IDX_W     = $clog2(NUM_SLOTS);
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int SLOT_W    = 10;
  localparam int STAT_W    = 2;
  localparam int TDATA_W   = ((SLOT_W + 7) / 8) * 8;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_NOT_IN_USE = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0] free_count;
    logic [CNT_W-1:0] low_mark;
  } stat_t;

endpackage

`default_nettype wire

// ----- design/index_free_list_allocator_core.sv -----
// top level of the index free list allocator
`default_nettype none

// Hands out slot indices 0..1023 from a last-in-first-out free stack and takes
// them back, with one in-use bit per slot. in_tuser carries the command
// (allocate or free) and in_tdata the index to free; each transaction yields
// exactly one result with the granted index in out_tdata and the status in
// out_tuser (ok, pool empty, index not in use). The idle state takes a
// transaction and reads the stack and in-use memories; the exec state writes
// them back and loads the result register, waiting while the result register
// cannot drain, and no new transaction is taken before it is done. A low-water
// mark of the stack depth stands in for the reset contents of both memories,
// so the block is ready right after reset with no clearing pass.

`include "index_free_list_allocator_core_assert.svh"

module index_free_list_allocator_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [ifla_pkg::TDATA_W-1:0]  in_tdata,   // slot_index
  input  wire logic                          in_tuser,   // cmd
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [ifla_pkg::TDATA_W-1:0]       out_tdata,  // granted_index
  output logic [ifla_pkg::STAT_W-1:0]        out_tuser   // status
);

  localparam int SW = ifla_pkg::SLOT_W;
  localparam int DW = ifla_pkg::TDATA_W;

  ifla_pkg::ctl_t  ctl;
  ifla_pkg::stat_t stat;
  logic [SW-1:0]   granted;

  ifla_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl)
  );

  ifla_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .in_cmd            (in_tuser),
    .in_slot_index     (in_tdata[SW-1:0]),
    .out_granted_index (granted),
    .out_status        (out_tuser),
    .stat              (stat)
  );

  assign out_tdata = DW'(granted);

  `IFLA_ASSERT(a_busy_after_accept, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready)
  `IFLA_ASSERT(a_exec_no_overwrite, clk, rst_n, ctl.exec |-> (!out_tvalid || out_tready))
  `IFLA_ASSERT(a_count_bounded, clk, rst_n,
    (stat.low_mark <= stat.free_count) && (stat.free_count <= ifla_pkg::CNT_W'(ifla_pkg::NUM_SLOTS)))
  `IFLA_ASSERT_ALWAYS(a_cmd_exclusive, clk, !(ctl.capture && ctl.exec))

endmodule

`default_nettype wire

// ----- design/ifla_ctrl.sv -----
// controller state machine: accepts a transaction, runs the update, loads the result
`default_nettype none

module ifla_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output ifla_pkg::ctl_t     ctl
);

  ifla_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ifla_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    ctl.capture   = 1'b0;
    ctl.exec      = 1'b0;
    unique case (state_r)
      ifla_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.capture = 1'b1;
          state_nxt   = ifla_pkg::S_EXEC;
        end
      end
      ifla_pkg::S_EXEC: begin
        // result register must be free or draining
        if (!out_valid_r || out_tready) begin
          ctl.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ifla_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ifla_pkg::S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ----- design/ifla_dp.sv -----
// datapath: free stack memory, in-use memory, count, low-water mark, result register
`default_nettype none

module ifla_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ifla_pkg::ctl_t                ctl,
  input  wire logic                          in_cmd,
  input  wire logic [ifla_pkg::SLOT_W-1:0]   in_slot_index,
  output logic [ifla_pkg::SLOT_W-1:0]        out_granted_index,
  output logic [ifla_pkg::STAT_W-1:0]        out_status,
  output ifla_pkg::stat_t                    stat
);

  localparam int IW = ifla_pkg::IDX_W;
  localparam int CW = ifla_pkg::CNT_W;
  localparam int SW = ifla_pkg::SLOT_W;
  localparam int N  = ifla_pkg::NUM_SLOTS;

  logic [IW-1:0] stack_mem [N];
  logic          use_mem   [N];

  ifla_pkg::cmd_t cmd_r;
  logic [SW-1:0]  idx_r;
  logic [IW-1:0]  stk_rd_r;
  logic           use_rd_r;
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  low_r, low_nxt;
  logic [SW-1:0]  out_idx_r, out_idx_nxt;
  ifla_pkg::status_t out_stat_r, out_stat_nxt;

  logic [CW-1:0] rd_pos;
  logic [CW-1:0] top_pos;
  logic [IW-1:0] pop_val;
  logic          idx_valid;
  logic          in_use;
  logic          alloc_ok;
  logic          free_ok;
  logic          use_we;
  logic [IW-1:0] use_waddr;
  logic          use_wdata;
  logic          stk_we;

  // entries below the low-water mark still hold their reset contents
  assign rd_pos    = count_r - CW'(1);
  assign top_pos   = count_r - CW'(1);
  assign pop_val   = (top_pos < low_r) ? top_pos[IW-1:0] : stk_rd_r;
  assign idx_valid = ({{(32-SW){1'b0}}, idx_r} < 32'(N));
  assign in_use    = idx_valid && (CW'(idx_r) >= low_r) && use_rd_r;
  assign alloc_ok  = (cmd_r == ifla_pkg::CMD_ALLOC) && (count_r != '0);
  assign free_ok   = (cmd_r == ifla_pkg::CMD_FREE) && in_use && (count_r != CW'(N));

  assign use_we    = ctl.exec && (alloc_ok || free_ok);
  assign use_waddr = alloc_ok ? pop_val : idx_r[IW-1:0];
  assign use_wdata = alloc_ok;
  assign stk_we    = ctl.exec && free_ok;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r    <= ifla_pkg::cmd_t'(in_cmd);
      idx_r    <= in_slot_index;
      stk_rd_r <= stack_mem[rd_pos[IW-1:0]];
      use_rd_r <= use_mem[in_slot_index[IW-1:0]];
    end
    if (stk_we) begin
      stack_mem[count_r[IW-1:0]] <= idx_r[IW-1:0];
    end
    if (use_we) begin
      use_mem[use_waddr] <= use_wdata;
    end
  end

  always_comb begin
    count_nxt    = count_r;
    low_nxt      = low_r;
    out_idx_nxt  = out_idx_r;
    out_stat_nxt = out_stat_r;
    if (ctl.exec) begin
      out_idx_nxt = '0;
      if (cmd_r == ifla_pkg::CMD_ALLOC) begin
        if (alloc_ok) begin
          count_nxt    = top_pos;
          out_idx_nxt  = SW'(pop_val);
          out_stat_nxt = ifla_pkg::ST_OK;
          if (top_pos < low_r) begin
            low_nxt = top_pos;
          end
        end else begin
          out_stat_nxt = ifla_pkg::ST_EMPTY;
        end
      end else begin
        if (free_ok) begin
          count_nxt    = count_r + CW'(1);
          out_stat_nxt = ifla_pkg::ST_OK;
        end else begin
          out_stat_nxt = ifla_pkg::ST_NOT_IN_USE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CW'(N);
      low_r   <= CW'(N);
    end else begin
      count_r <= count_nxt;
      low_r   <= low_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_idx_r  <= out_idx_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_granted_index = out_idx_r;
  assign out_status        = out_stat_r;
  assign stat.free_count   = count_r;
  assign stat.low_mark     = low_r;

endmodule

`default_nettype wire

// ----- bench/index_free_list_allocator_core_test.sv -----
// self-checking bench for the index free list allocator: directed table, then random traffic
`timescale 1ns / 100ps

module index_free_list_allocator_core_test;
  import ifla_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DIRECTED_N  = 24;
  localparam int RANDOM_PER_PHASE = 170;

  typedef struct packed {
    logic [SLOT_W-1:0] granted;
    status_t status;
  } reply_t;

  typedef struct {
    cmd_t cmd;
    logic [SLOT_W-1:0] idx;
    bit typed;
    logic [SLOT_W-1:0] granted;
    status_t status;
  } op_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = CMD_ALLOC;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic [STAT_W-1:0] out_tuser;

  // allocator image kept by the bench
  logic [SLOT_W-1:0] free_stack_m [NUM_SLOTS];
  int free_depth;
  bit slot_busy [NUM_SLOTS];

  reply_t alloc_replies [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  op_row_t directed_ops [DIRECTED_N] = '{
    '{CMD_FREE,  10'd0,    1'b1, 10'd0,    ST_NOT_IN_USE},
    '{CMD_FREE,  10'd1023, 1'b1, 10'd0,    ST_NOT_IN_USE},
    '{CMD_ALLOC, 10'd1023, 1'b1, 10'd1023, ST_OK},
    '{CMD_ALLOC, 10'd0,    1'b1, 10'd1022, ST_OK},
    '{CMD_FREE,  10'd1022, 1'b1, 10'd0,    ST_OK},
    '{CMD_FREE,  10'd1022, 1'b1, 10'd0,    ST_NOT_IN_USE},
    '{CMD_ALLOC, 10'd0,    1'b1, 10'd1022, ST_OK},
    '{CMD_FREE,  10'd1023, 1'b1, 10'd0,    ST_OK},
    '{CMD_FREE,  10'd1022, 1'b1, 10'd0,    ST_OK},
    '{CMD_ALLOC, 10'd682,  1'b1, 10'd1022, ST_OK},
    '{CMD_ALLOC, 10'd341,  1'b1, 10'd1023, ST_OK},
    '{CMD_FREE,  10'd682,  1'b1, 10'd0,    ST_NOT_IN_USE},
    '{CMD_FREE,  10'd341,  1'b1, 10'd0,    ST_NOT_IN_USE},
    '{CMD_ALLOC, 10'd0,    1'b1, 10'd1021, ST_OK},
    '{CMD_FREE,  10'd1021, 1'b1, 10'd0,    ST_OK},
    '{CMD_FREE,  10'd1023, 1'b1, 10'd0,    ST_OK},
    '{CMD_FREE,  10'd1022, 1'b1, 10'd0,    ST_OK},
    '{CMD_ALLOC, 10'd0,    1'b1, 10'd1022, ST_OK},
    '{CMD_ALLOC, 10'd0,    1'b1, 10'd1023, ST_OK},
    '{CMD_ALLOC, 10'd0,    1'b1, 10'd1021, ST_OK},
    '{CMD_ALLOC, 10'd512,  1'b0, 10'd0,    ST_OK},
    '{CMD_FREE,  10'd1020, 1'b0, 10'd0,    ST_OK},
    '{CMD_FREE,  10'd1023, 1'b0, 10'd0,    ST_OK},
    '{CMD_ALLOC, 10'd0,    1'b0, 10'd0,    ST_OK}
  };

  index_free_list_allocator_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  function automatic void reset_allocator_image();
    for (int k = 0; k < NUM_SLOTS; k++) begin
      free_stack_m[k] = k[SLOT_W-1:0];
      slot_busy[k] = 1'b0;
    end
    free_depth = NUM_SLOTS;
  endfunction

  function automatic reply_t apply_slot_op(cmd_t cmd, logic [SLOT_W-1:0] idx);
    reply_t r;
    r.granted = '0;
    r.status = ST_OK;
    if (cmd == CMD_ALLOC) begin
      if (free_depth == 0) begin
        r.status = ST_EMPTY;
      end else begin
        free_depth--;
        r.granted = free_stack_m[free_depth];
        slot_busy[r.granted] = 1'b1;
      end
    end else begin
      if (!slot_busy[idx] || free_depth >= NUM_SLOTS) begin
        r.status = ST_NOT_IN_USE;
      end else begin
        slot_busy[idx] = 1'b0;
        free_stack_m[free_depth] = idx;
        free_depth++;
      end
    end
    return r;
  endfunction

  // a slot currently handed out, or a random one when none is
  function automatic logic [SLOT_W-1:0] pick_busy_slot();
    int start;
    int s;
    start = $urandom_range(0, NUM_SLOTS - 1);
    for (int k = 0; k < NUM_SLOTS; k++) begin
      s = (start + k) % NUM_SLOTS;
      if (slot_busy[s]) return s[SLOT_W-1:0];
    end
    return start[SLOT_W-1:0];
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic put_op(cmd_t cmd, logic [SLOT_W-1:0] idx, bit typed, reply_t typed_reply);
    reply_t r;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {{(TDATA_W - SLOT_W){1'b0}}, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = apply_slot_op(cmd, idx);
    alloc_replies.insert(alloc_replies.size(), typed ? typed_reply : r);
    @(negedge clk);
  endtask

  task automatic drain_replies();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (alloc_replies.size() != 0);
  endtask

  task automatic random_ops(int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        put_op(CMD_ALLOC, SLOT_W'($urandom_range(0, NUM_SLOTS - 1)), 1'b0, '0);
      else if (pick < 85)
        put_op(CMD_FREE, pick_busy_slot(), 1'b0, '0);
      else
        put_op(CMD_FREE, SLOT_W'($urandom_range(0, NUM_SLOTS - 1)), 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    out_tready <= (recv_stall_pct == 0) ? 1'b1 : ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (alloc_replies.size() == 0) begin
        $display("%0t: unexpected result transaction, data %0d status %0d",
                 $time, out_tdata, out_tuser);
        errors++;
      end else begin
        want = alloc_replies.pop_front();
        if (out_tdata !== {{(TDATA_W - SLOT_W){1'b0}}, want.granted}) begin
          $display("%0t: granted index expected %0d actual %0d", $time, want.granted, out_tdata);
          errors++;
        end
        if (out_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    reset_allocator_image();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIRECTED_N; i++) begin
      put_op(directed_ops[i].cmd, directed_ops[i].idx, directed_ops[i].typed,
             '{granted: directed_ops[i].granted, status: directed_ops[i].status});
    end
    drain_replies();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      random_ops(RANDOM_PER_PHASE);
      drain_replies();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && alloc_replies.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
